// ===== sv/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// rna_pkg
// Shared sizes, types and helpers for the radix number to ASCII converter.
// ----------------------------------------------------------------------------
package rna_pkg;

    // sizes of the conversion
    localparam int MAX_DIGITS = 16;
    localparam int VALUE_BITS = 16;

    // fixed field widths
    localparam int NUMBER_W = 16;
    localparam int MINW_IN_W = 5;
    localparam int BASE_W   = 5;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    // derived widths
    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int MINW_W = $clog2(MAX_DIGITS + 1);
    localparam int CNT_W  = $clog2(VALUE_BITS + MAX_DIGITS);

    // radix limits and character constants
    localparam logic [BASE_W-1:0]  BASE_MIN  = BASE_W'(2);
    localparam logic [BASE_W-1:0]  BASE_TOP  = BASE_W'(16);
    localparam logic [DIGIT_W-1:0] DEC_TOP   = DIGIT_W'(9);
    localparam logic [CHAR_W-1:0]  ZERO_CHAR = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ALPHA_GAP = CHAR_W'(7);
    localparam logic [CHAR_W-1:0]  NINE_CHAR = CHAR_W'(57);
    localparam logic [CHAR_W-1:0]  A_CHAR    = CHAR_W'(65);
    localparam logic [CHAR_W-1:0]  F_CHAR    = CHAR_W'(70);

    typedef logic [DIGIT_W-1:0] digit_t;

    // one doubling step passed from cell to cell
    typedef struct packed {
        logic en;
        logic carry;
    } step_t;

    // digit value to uppercase ASCII
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input digit_t d);
        logic [CHAR_W-1:0] ch;
        ch = CHAR_W'(d) + ZERO_CHAR;
        if (d > DEC_TOP) begin
            ch = ch + ALPHA_GAP;
        end
        return ch;
    endfunction

endpackage

// ===== sv/radix_number_to_ascii_top.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_ascii_top
// Converts an unsigned value to zero-padded ASCII digits in radix 2 to 16.
// Operation: the value is shifted in one bit per cycle, msb first, and the
// carry wave ripples through the digit row; the emitter then drops leading
// zeros beyond the minimum count and sends the digits. A new value is taken
// only in idle, once the last digit of the previous one has been accepted.
// Reset: synchronous active-low aresetn returns to idle, no request pending.
// ----------------------------------------------------------------------------
module radix_number_to_ascii_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] number, [20:16] min_digits, [25:21] base, [31:26] zero
    input  logic [rna_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [6:0] digit_char, [7] zero
    output logic [rna_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import rna_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam logic [CNT_W-1:0] CONV_END  = CNT_W'(VALUE_BITS + MAX_DIGITS - 1);
    localparam logic [CNT_W-1:0] FEED_LEN  = CNT_W'(VALUE_BITS);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [BASE_W-1:0]      base_reg, base_next;
    logic [MINW_W-1:0]      minw_reg, minw_next;

    logic [NUMBER_W-1:0]    in_number;
    logic [MINW_IN_W-1:0]   in_minw;
    logic [BASE_W-1:0]      in_base;
    logic                   accept;
    logic                   start;
    logic                   emit_busy;
    step_t                  feed;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [CHAR_W-1:0]      out_char;

    assign in_number = s_tdata[NUMBER_W-1:0];
    assign in_minw   = s_tdata[NUMBER_W +: MINW_IN_W];
    assign in_base   = s_tdata[NUMBER_W + MINW_IN_W +: BASE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign start    = (state_reg == ST_CONV) && (cnt_reg == CONV_END);

    // feed the value msb first into the low digit
    assign feed.en    = (state_reg == ST_CONV) && (cnt_reg < FEED_LEN);
    assign feed.carry = val_reg[VALUE_BITS-1];

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        base_next  = base_reg;
        minw_next  = minw_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CONV;
                    cnt_next   = '0;
                    val_next   = VALUE_BITS'(in_number);
                    // clamp radix into range
                    if (in_base < BASE_MIN) begin
                        base_next = BASE_MIN;
                    end else if (in_base > BASE_TOP) begin
                        base_next = BASE_TOP;
                    end else begin
                        base_next = in_base;
                    end
                    // clamp minimum digit count into range
                    if (in_minw == '0) begin
                        minw_next = MINW_W'(1);
                    end else if (32'(in_minw) > MAX_DIGITS) begin
                        minw_next = MINW_W'(MAX_DIGITS);
                    end else begin
                        minw_next = MINW_W'(in_minw);
                    end
                end
            end
            ST_CONV: begin
                cnt_next = cnt_reg + 1'b1;
                if (feed.en) begin
                    val_next = {val_reg[VALUE_BITS-2:0], 1'b0};
                end
                if (start) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        base_reg <= base_next;
        minw_reg <= minw_next;
    end

    // digit row
    rna_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (accept),
        .base    (base_reg),
        .step_in (feed),
        .digits  (digits)
    );

    // leading zero scan and output register
    rna_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .minw      (minw_reg),
        .digits    (digits),
        .busy      (emit_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(M_DATA_W - CHAR_W){1'b0}}, out_char};

    property p_idle_quiet;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !emit_busy;
    endproperty
    a_idle_quiet: assert property (p_idle_quiet)
        else $error("idle while digits pending");

    property p_cnt_bound;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> (cnt_reg <= CONV_END);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound)
        else $error("conversion counter overran");

    property p_accept_conv;
        @(posedge aclk) disable iff (!aresetn)
        accept |=> ((state_reg == ST_CONV) && (cnt_reg == '0));
    endproperty
    a_accept_conv: assert property (p_accept_conv)
        else $error("request not started");

endmodule

// ===== sv/rna_cell.sv =====
// ----------------------------------------------------------------------------
// rna_cell
// One digit of the radix accumulator: on each step doubles its digit, adds
// the incoming carry and passes a registered carry on to the next digit.
// ----------------------------------------------------------------------------
module rna_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic [rna_pkg::BASE_W-1:0] base,
    input  rna_pkg::step_t           step_in,
    output rna_pkg::step_t           step_out,
    output rna_pkg::digit_t          digit
);
    import rna_pkg::*;

    digit_t                digit_reg, digit_next;
    step_t                 step_reg, step_next;
    logic [DIGIT_W:0]      dbl;
    logic                  wrap;

    // double and add carry, fold back below the radix
    assign dbl  = {digit_reg, step_in.carry};
    assign wrap = (dbl >= base);

    always_comb begin
        digit_next = digit_reg;
        step_next  = '0;
        if (clear) begin
            digit_next = '0;
        end else if (step_in.en) begin
            digit_next     = wrap ? DIGIT_W'(dbl - (DIGIT_W+1)'(base)) : DIGIT_W'(dbl);
            step_next.en    = 1'b1;
            step_next.carry = wrap;
        end
    end

    // step token is control, digit is payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign step_out = step_reg;
    assign digit    = digit_reg;

endmodule

// ===== sv/rna_conv.sv =====
// ----------------------------------------------------------------------------
// rna_conv
// Systolic row of digit cells. Value bits enter one per cycle at the low
// digit; carries ripple up one cell per cycle as a skewed wavefront.
// ----------------------------------------------------------------------------
module rna_conv (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         clear,
    input  logic [rna_pkg::BASE_W-1:0]                   base,
    input  rna_pkg::step_t                               step_in,
    output logic [rna_pkg::MAX_DIGITS-1:0][rna_pkg::DIGIT_W-1:0] digits
);
    import rna_pkg::*;

    step_t steps [MAX_DIGITS+1];

    assign steps[0] = step_in;

    // one cell per output digit, top carry dropped
    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
        rna_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (clear),
            .base     (base),
            .step_in  (steps[i]),
            .step_out (steps[i+1]),
            .digit    (digits[i])
        );
    end

    // a cell steps only in the cycle after its lower neighbor stepped
    property p_wave;
        @(posedge aclk) disable iff (!aresetn)
        (steps[1].en && !$past(clear)) |-> $past(step_in.en);
    endproperty
    a_wave: assert property (p_wave)
        else $error("digit wave out of order");

    property p_carry_en;
        @(posedge aclk) disable iff (!aresetn)
        steps[1].carry |-> steps[1].en;
    endproperty
    a_carry_en: assert property (p_carry_en)
        else $error("carry without step");

    property p_clear;
        @(posedge aclk) disable iff (!aresetn)
        clear |=> (digits[0] == '0);
    endproperty
    a_clear: assert property (p_clear)
        else $error("digit not cleared");

    // the value always fits the digit row
    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn)
        steps[MAX_DIGITS].en |-> !steps[MAX_DIGITS].carry;
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("carry out of top digit");

endmodule

// ===== sv/rna_emit.sv =====
// ----------------------------------------------------------------------------
// rna_emit
// Digit shifter and output register: drops leading zeros beyond the minimum
// count, then sends one ASCII digit per request, most significant first.
// ----------------------------------------------------------------------------
module rna_emit (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    input  logic [rna_pkg::MINW_W-1:0]                   minw,
    input  logic [rna_pkg::MAX_DIGITS-1:0][rna_pkg::DIGIT_W-1:0] digits,
    output logic                                         busy,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [rna_pkg::CHAR_W-1:0]                   out_char,
    output logic                                         out_last
);
    import rna_pkg::*;

    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] dig_reg, dig_next;
    logic [IDX_W-1:0]                   pos_reg, pos_next;
    logic [MINW_W-1:0]                  minw_reg, minw_next;
    logic                               active_reg, active_next;
    logic                               valid_reg, valid_next;
    logic [CHAR_W-1:0]                  char_reg, char_next;
    logic                               last_reg, last_next;
    digit_t                             top_digit;
    logic                               skip;
    logic                               can_load;

    assign top_digit = dig_reg[MAX_DIGITS-1];
    assign can_load  = !valid_reg || out_ready;
    assign skip      = (MINW_W'(pos_reg) >= minw_reg) && (top_digit == '0);

    // scan down from the top digit
    always_comb begin
        dig_next    = dig_reg;
        pos_next    = pos_reg;
        minw_next   = minw_reg;
        active_next = active_reg;
        valid_next  = valid_reg && !out_ready;
        char_next   = char_reg;
        last_next   = last_reg;
        if (start) begin
            dig_next    = digits;
            pos_next    = IDX_W'(MAX_DIGITS - 1);
            minw_next   = minw;
            active_next = 1'b1;
        end else if (active_reg) begin
            if (skip) begin
                dig_next = {dig_reg[MAX_DIGITS-2:0], digit_t'(0)};
                pos_next = pos_reg - 1'b1;
            end else if (can_load) begin
                valid_next = 1'b1;
                char_next  = digit_to_ascii(top_digit);
                last_next  = (pos_reg == '0);
                dig_next   = {dig_reg[MAX_DIGITS-2:0], digit_t'(0)};
                pos_next   = pos_reg - 1'b1;
                // inner zeros are kept once the first digit is out
                minw_next  = MINW_W'(MAX_DIGITS);
                if (pos_reg == '0) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dig_reg  <= dig_next;
        pos_reg  <= pos_next;
        minw_reg <= minw_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = active_reg || valid_reg;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    property p_start_idle;
        @(posedge aclk) disable iff (!aresetn)
        start |-> !busy;
    endproperty
    a_start_idle: assert property (p_start_idle)
        else $error("new value while digits pending");

    property p_last_done;
        @(posedge aclk) disable iff (!aresetn)
        (valid_reg && last_reg) |-> !active_reg;
    endproperty
    a_last_done: assert property (p_last_done)
        else $error("last digit sent while scan active");

    property p_char_range;
        @(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (((char_reg >= ZERO_CHAR) && (char_reg <= NINE_CHAR)) ||
                       ((char_reg >= A_CHAR) && (char_reg <= F_CHAR)));
    endproperty
    a_char_range: assert property (p_char_range)
        else $error("digit character out of range");

endmodule

// ===== tb/tb_radix_number_to_ascii_top.sv =====
// ----------------------------------------------------------------------------
// tb_radix_number_to_ascii_top
// Self-checking bench for the radix number to ASCII converter. A directed
// table covers the field extremes, the radix and width clamps and the padding.
// Random requests follow. Every digit leaving the block is compared with the
// typed text or an in-bench conversion model, with random gaps on both
// streams and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_radix_number_to_ascii_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rna_pkg::*;

    localparam int RANDOM_REQUESTS = 446;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 60;
    localparam int DRAIN_CYCLES    = 60;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd65;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // one expected output digit
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_rec_t;

    // directed request, text empty where the model decides
    typedef struct {
        logic [NUMBER_W-1:0]  number;
        logic [MINW_IN_W-1:0] minw;
        logic [BASE_W-1:0]    base;
        string                text;
    } vector_t;

    digit_rec_t pending_digits[$];
    int         fail_count     = 0;
    int         digits_checked = 0;

    vector_t directed_vectors [24] = '{
        '{16'd0,      5'd0,  5'd10, "0"},
        '{16'd0,      5'd1,  5'd10, "0"},
        '{16'd0,      5'd16, 5'd2,  "0000000000000000"},
        '{16'd0,      5'd31, 5'd10, "0000000000000000"},
        '{16'hFFFF,   5'd0,  5'd16, "FFFF"},
        '{16'hFFFF,   5'd0,  5'd2,  "1111111111111111"},
        '{16'hFFFF,   5'd0,  5'd10, "65535"},
        '{16'hFFFF,   5'd0,  5'd8,  "177777"},
        '{16'd5,      5'd0,  5'd0,  "101"},
        '{16'd5,      5'd0,  5'd1,  "101"},
        '{16'd255,    5'd0,  5'd31, "FF"},
        '{16'd255,    5'd0,  5'd17, "FF"},
        '{16'd10,     5'd4,  5'd16, "000A"},
        '{16'hABCD,   5'd0,  5'd16, "ABCD"},
        '{16'd12345,  5'd8,  5'd10, "00012345"},
        '{16'd35,     5'd0,  5'd12, "2B"},
        '{16'd9,      5'd0,  5'd10, "9"},
        '{16'd1,      5'd16, 5'd16, "0000000000000001"},
        '{16'd15,     5'd0,  5'd15, "10"},
        '{16'd14,     5'd0,  5'd15, "E"},
        '{16'd100,    5'd0,  5'd3,  ""},
        '{16'h8001,   5'd20, 5'd7,  ""},
        '{16'h5555,   5'd3,  5'd13, ""},
        '{16'hAAAA,   5'd15, 5'd9,  ""}
    };

    radix_number_to_ascii_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10ms;
        $display("radix_number_to_ascii_top regression: fail");
        $finish;
    end

    // conversion model: queue the digits of one request, most significant first
    function automatic void predict_digits(input logic [NUMBER_W-1:0] number,
                                           input logic [MINW_IN_W-1:0] minw_raw,
                                           input logic [BASE_W-1:0] base_raw);
        int unsigned value;
        int unsigned radix;
        int unsigned width;
        int unsigned rem;
        int          count;
        logic [CHAR_W-1:0] chars [MAX_DIGITS];
        value = number;
        width = minw_raw;
        radix = base_raw;
        // clamp width to 1..MAX_DIGITS and radix to 2..16
        if (width < 1) width = 1;
        if (width > MAX_DIGITS) width = MAX_DIGITS;
        if (radix < 2) radix = 2;
        if (radix > 16) radix = 16;
        count = 0;
        do begin
            rem = value % radix;
            chars[count] = (rem > 9) ? CHAR_ALPHA + CHAR_W'(rem - 10)
                                     : CHAR_ZERO + CHAR_W'(rem);
            count++;
            value = value / radix;
        end while (count < MAX_DIGITS && (count < int'(width) || value != 0));
        for (int k = count - 1; k >= 0; k--) begin
            pending_digits.push_back(digit_rec_t'{chars[k], k == 0});
        end
    endfunction

    // queue digits typed in as text
    function automatic void push_text(input string text);
        byte c;
        for (int i = 0; i < text.len(); i++) begin
            c = text[i];
            pending_digits.push_back(digit_rec_t'{c[CHAR_W-1:0], i == text.len() - 1});
        end
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_request(input logic [NUMBER_W-1:0] number,
                                                         input logic [MINW_IN_W-1:0] minw,
                                                         input logic [BASE_W-1:0] base);
        return S_DATA_W'({base, minw, number});
    endfunction

    // offer one request after a gap, return at the falling edge after acceptance
    task automatic send_request(input logic [S_DATA_W-1:0] word, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // output checker
    always @(posedge aclk) begin
        digit_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            digits_checked++;
            if (pending_digits.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected digit, expected none, actual char %h last %b",
                         $time, m_tdata[CHAR_W-1:0], m_tlast);
            end else begin
                want = pending_digits.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.ch || m_tlast !== want.last) begin
                    fail_count++;
                    $display("%0t: digit mismatch, expected char %h last %b, actual char %h last %b",
                             $time, want.ch, want.last, m_tdata[CHAR_W-1:0], m_tlast);
                end
            end
        end
    end

    // receiver: random stalls, quiet stretches and one long hold-off
    initial begin
        bit burst;
        bit hold_done;
        int stall;
        burst     = 1'b0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) burst = ~burst;
            stall = burst ? 0 : $urandom_range(0, 12);
            if (!hold_done && digits_checked >= HOLD_AFTER) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // reset, stimulus and end of run
    initial begin
        bit burst;
        int gap;
        logic [NUMBER_W-1:0]  number;
        logic [MINW_IN_W-1:0] minw;
        logic [BASE_W-1:0]    base;
        burst    = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        foreach (directed_vectors[i]) begin
            gap = $urandom_range(0, 12);
            send_request(pack_request(directed_vectors[i].number, directed_vectors[i].minw,
                                      directed_vectors[i].base), gap);
            if (directed_vectors[i].text.len() != 0) begin
                push_text(directed_vectors[i].text);
            end else begin
                predict_digits(directed_vectors[i].number, directed_vectors[i].minw,
                               directed_vectors[i].base);
            end
        end

        // random requests
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            case ($urandom_range(0, 5))
                0: number = NUMBER_W'($urandom_range(0, 15));
                1: number = NUMBER_W'($urandom_range(0, 255));
                2: number = ($urandom_range(0, 1) != 0) ? '1 : NUMBER_W'(1) << $urandom_range(0, 15);
                default: number = NUMBER_W'($urandom);
            endcase
            minw = ($urandom_range(0, 9) < 8) ? MINW_IN_W'($urandom_range(0, 16))
                                              : MINW_IN_W'($urandom_range(0, 31));
            case ($urandom_range(0, 9))
                0, 1: base = BASE_W'($urandom_range(0, 31));
                2:    base = BASE_W'(2);
                default: base = BASE_W'($urandom_range(2, 16));
            endcase
            if ($urandom_range(0, 29) == 0) burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, 12);
            send_request(pack_request(number, minw, base), gap);
            predict_digits(number, minw, base);
        end
        s_tvalid <= 1'b0;

        // drain outstanding digits, then let the block settle
        while (pending_digits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_digits.size() == 0) begin
            $display("radix_number_to_ascii_top regression: pass");
        end else begin
            $display("radix_number_to_ascii_top regression: fail");
        end
        $finish;
    end

endmodule
